// ----- sv/i2c_register_access_master_assert.svh -----
// Assertion macros shared by the I2C register access master RTL.
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/i2cm_pkg.sv -----
// Package with the sequencer state type, codes and step functions of the I2C master.
package i2cm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] CFG_PHASE_TICKS = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd255;

  // Segment kinds of the bus program.
  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_START = 3'd1;
  localparam logic [2:0] K_WBYTE = 3'd2;
  localparam logic [2:0] K_RBYTE = 3'd3;
  localparam logic [2:0] K_STOP  = 3'd4;

  localparam logic [2:0] PH_ACK_WAIT = 3'd5;
  localparam logic [2:0] PH_LAST     = 3'd6;

  typedef struct packed {
    logic [2:0] seg;
    logic [2:0] ph;
    logic [3:0] bit_cnt;
    logic [7:0] phase_cnt;
    logic [7:0] ack_cnt;
    logic [7:0] shift;
    logic [6:0] dev;
    logic [7:0] regad;
    logic [7:0] data;
    logic       is_read;
    logic       scl;
    logic       sda;
    logic       ack_flag;
    logic [7:0] rx;
  } i2cm_state_t;

  typedef struct packed {
    logic done;
    logic rejected;
  } i2cm_flags_t;

  // Idle sequencer with both bus lines released.
  function automatic i2cm_state_t idle_state();
    i2cm_state_t r;
    r = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    return r;
  endfunction

  function automatic logic [2:0] kind_of(logic is_read, logic [2:0] seg);
    logic [2:0] k;
    k = K_NONE;
    if (is_read) begin
      case (seg)
        3'd1, 3'd4:       k = K_START;
        3'd2, 3'd3, 3'd5: k = K_WBYTE;
        3'd6:             k = K_RBYTE;
        3'd7:             k = K_STOP;
        default:          k = K_NONE;
      endcase
    end else begin
      case (seg)
        3'd1:             k = K_START;
        3'd2, 3'd3, 3'd4: k = K_WBYTE;
        3'd5:             k = K_STOP;
        default:          k = K_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [7:0] byte_for(i2cm_state_t s, logic [2:0] seg);
    logic [7:0] devb;
    logic [7:0] b;
    devb = {s.dev, 1'b0};
    case (seg)
      3'd2:    b = devb;
      3'd3:    b = s.regad;
      3'd4:    b = s.is_read ? 8'd0 : s.data;
      3'd5:    b = s.is_read ? (devb | 8'd1) : 8'd0;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic i2cm_state_t enter_phase(i2cm_state_t s, logic [2:0] seg,
                                              logic [2:0] ph);
    i2cm_state_t r;
    r = s;
    r.seg = seg;
    r.ph = ph;
    r.phase_cnt = 8'd0;
    case (kind_of(s.is_read, seg))
      K_START: begin
        if (ph == 3'd0) r.sda = 1'b1;
        else if (ph == 3'd1) r.scl = 1'b1;
        else r.sda = 1'b0;
      end
      K_WBYTE: begin
        case (ph)
          3'd0: r.scl = 1'b0;
          3'd1: r.sda = s.shift[7];
          3'd2: r.scl = 1'b1;
          3'd3: r.scl = 1'b0;
          3'd4: r.sda = 1'b1;
          3'd5: begin
            r.scl = 1'b1;
            r.ack_cnt = 8'd0;
          end
          default: r.scl = 1'b0;
        endcase
      end
      K_RBYTE: begin
        if (ph == 3'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else begin
          r.scl = (ph == 3'd1) || (ph == 3'd3);
        end
      end
      K_STOP: begin
        if (ph == 3'd0) r.sda = 1'b0;
        else if (ph == 3'd1) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      default: r.seg = s.seg;
    endcase
    return r;
  endfunction

  function automatic i2cm_state_t begin_segment(i2cm_state_t s, logic [3:0] seg);
    i2cm_state_t r;
    r = s;
    if (seg[3] || (kind_of(s.is_read, seg[2:0]) == K_NONE)) begin
      r.seg = 3'd0;
      r.ph = 3'd0;
    end else begin
      r.bit_cnt = 4'd0;
      r.shift = byte_for(s, seg[2:0]);
      r = enter_phase(r, seg[2:0], 3'd0);
    end
    return r;
  endfunction

  function automatic i2cm_state_t advance(i2cm_state_t s);
    i2cm_state_t r;
    logic [3:0]  seg_inc;
    r = s;
    seg_inc = {1'b0, s.seg} + 4'd1;
    case (kind_of(s.is_read, s.seg))
      K_START: begin
        if (s.ph < 3'd2) r = enter_phase(s, s.seg, s.ph + 3'd1);
        else r = begin_segment(s, seg_inc);
      end
      K_WBYTE: begin
        if (s.ph == 3'd2) begin
          r.shift = {s.shift[6:0], 1'b0};
          r.bit_cnt = s.bit_cnt + 4'd1;
          r = enter_phase(r, s.seg, (r.bit_cnt < 4'd8) ? 3'd0 : 3'd3);
        end else if (s.ph < PH_LAST) begin
          r = enter_phase(s, s.seg, s.ph + 3'd1);
        end else begin
          r = begin_segment(s, seg_inc);
        end
      end
      K_RBYTE: begin
        if (s.ph == 3'd2) begin
          r.bit_cnt = s.bit_cnt + 4'd1;
          r = enter_phase(r, s.seg, (r.bit_cnt < 4'd8) ? 3'd1 : 3'd3);
        end else if (s.ph < 3'd4) begin
          r = enter_phase(s, s.seg, s.ph + 3'd1);
        end else begin
          r.rx = s.shift;
          r = begin_segment(r, seg_inc);
        end
      end
      K_STOP: begin
        if (s.ph < 3'd2) begin
          r = enter_phase(s, s.seg, s.ph + 3'd1);
        end else begin
          r.seg = 3'd0;
          r.ph = 3'd0;
          r.phase_cnt = 8'd0;
        end
      end
      default: begin
        r.seg = 3'd0;
        r.ph = 3'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- sv/i2cm_step.sv -----
// Next-state logic of the I2C master sequencer for one tick or command.
module i2cm_step
  import i2cm_pkg::*;
(
  input  i2cm_state_t state,
  input  logic [1:0]  cmd,
  input  logic [6:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  wr_byte,
  input  logic        sda_in,
  input  logic [7:0]  phase_ticks,
  input  logic [7:0]  ack_timeout,
  output i2cm_state_t state_nxt,
  output i2cm_flags_t flags
);

  logic       busy;
  logic       is_cmd;
  logic [2:0] kind;

  assign busy   = (state.seg != 3'd0);
  assign is_cmd = (cmd == CMD_WRITE) || (cmd == CMD_READ);
  assign kind   = kind_of(state.is_read, state.seg);

  always_comb begin
    state_nxt = state;
    flags = '0;
    if (is_cmd && !busy) begin
      state_nxt.dev = dev_addr;
      state_nxt.regad = reg_addr;
      state_nxt.data = wr_byte;
      state_nxt.is_read = (cmd == CMD_READ);
      state_nxt.ack_flag = 1'b0;
      state_nxt = begin_segment(state_nxt, 4'd1);
    end else begin
      flags.rejected = is_cmd;
      if (busy) begin
        if ((kind == K_WBYTE) && (state.ph == PH_ACK_WAIT)) begin
          // SCL is high here; the slave ends the wait by pulling SDA low.
          if (!sda_in) begin
            state_nxt = advance(state);
          end else begin
            if (state.ack_cnt != 8'hFF) state_nxt.ack_cnt = state.ack_cnt + 8'd1;
            if (state_nxt.ack_cnt >= ack_timeout) begin
              state_nxt.ack_flag = 1'b1;
              state_nxt = advance(state_nxt);
            end
          end
        end else begin
          if (state.phase_cnt != 8'hFF) state_nxt.phase_cnt = state.phase_cnt + 8'd1;
          if (state_nxt.phase_cnt >= phase_ticks) begin
            flags.done = (kind == K_STOP) && (state.ph >= 3'd2);
            // Read bits are sampled on the last tick of the SCL-high phase.
            if ((kind == K_RBYTE) && (state.ph == 3'd1)) begin
              state_nxt.shift = {state.shift[6:0], sda_in};
            end
            state_nxt = advance(state_nxt);
          end
        end
      end
    end
  end

endmodule

// ----- sv/i2c_register_access_master.sv -----
// A result is registered and valid in the cycle after its input item is accepted.
// Throughput: one item per cycle while out_ready drains the result register; sequencer
// state and result register update in the accepting cycle, so items go back to back.
// Reset: synchronous active-low; the sequencer goes idle with SCL and SDA released,
// phase_ticks returns to 5, ack_timeout to 255, and no result is pending.
`include "i2c_register_access_master_assert.svh"

module i2c_register_access_master
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [6:0] in_dev_addr,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_wr_byte,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_data,
  output logic       out_ack_missing,
  output logic       out_cmd_rejected,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  i2cm_state_t state_r;
  i2cm_state_t state_nxt;
  i2cm_flags_t flags_nxt;
  logic [7:0]  phase_ticks_r;
  logic [7:0]  ack_timeout_r;
  logic        out_valid_r;
  logic        scl_r;
  logic        sda_r;
  logic        busy_r;
  logic        done_r;
  logic [7:0]  read_data_r;
  logic        ack_missing_r;
  logic        rejected_r;
  logic        in_xfer;
  logic        busy_nxt;
  logic        idle_now;
  logic        lines_up;
  logic        idle_tick;

  // The result register frees up when its transfer completes.
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign busy_nxt  = (state_nxt.seg != 3'd0);
  assign idle_now  = (state_r.seg == 3'd0);
  assign lines_up  = state_r.scl && state_r.sda;
  assign idle_tick = in_xfer && idle_now && (in_cmd != CMD_WRITE) && (in_cmd != CMD_READ);

  i2cm_step u_step (
    .state       (state_r),
    .cmd         (in_cmd),
    .dev_addr    (in_dev_addr),
    .reg_addr    (in_reg_addr),
    .wr_byte     (in_wr_byte),
    .sda_in      (in_sda_in),
    .phase_ticks (phase_ticks_r),
    .ack_timeout (ack_timeout_r),
    .state_nxt   (state_nxt),
    .flags       (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idle_state();
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      scl_r         <= state_nxt.scl;
      sda_r         <= state_nxt.sda;
      busy_r        <= busy_nxt;
      done_r        <= flags_nxt.done;
      read_data_r   <= state_nxt.rx;
      ack_missing_r <= state_nxt.ack_flag;
      rejected_r    <= flags_nxt.rejected;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_out      = scl_r;
  assign out_sda_out      = sda_r;
  assign out_busy_res     = busy_r;
  assign out_done_res     = done_r;
  assign out_read_data    = read_data_r;
  assign out_ack_missing  = ack_missing_r;
  assign out_cmd_rejected = rejected_r;

  `I2CM_ASSERT_NOW(a_idle_lines_released, idle_now, lines_up, "idle with a bus line low")
  `I2CM_ASSERT_NOW(a_done_goes_idle, in_xfer && flags_nxt.done, !busy_nxt, "done but busy")
  `I2CM_ASSERT_NOW(a_phase_in_range, 1'b1, state_r.ph <= PH_LAST, "phase out of range")
  `I2CM_ASSERT_NEXT(a_tick_keeps_idle, idle_tick, idle_now, "started without a command")

endmodule

// ----- sim/i2c_register_access_master_checker.sv -----
`timescale 1ns / 1ps
// Checker for the I2C register access master: predicts every bus tick and compares each result.
module i2c_register_access_master_checker
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [6:0] in_dev_addr,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_wr_byte,
  input  logic       in_sda_in,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_scl_out,
  input  logic       out_sda_out,
  input  logic       out_busy_res,
  input  logic       out_done_res,
  input  logic [7:0] out_read_data,
  input  logic       out_ack_missing,
  input  logic       out_cmd_rejected,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);

  // Segment kinds of each transaction type, segment 7 in the top three bits.
  localparam logic [23:0] WRITE_PLAN = {K_NONE, K_NONE, K_STOP, K_WBYTE,
                                        K_WBYTE, K_WBYTE, K_START, K_NONE};
  localparam logic [23:0] READ_PLAN  = {K_STOP, K_RBYTE, K_WBYTE, K_START,
                                        K_WBYTE, K_WBYTE, K_START, K_NONE};

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       ack_missing;
    logic       rejected;
  } bus_result_t;

  bus_result_t due_results[$];

  logic [7:0] hold_ticks;
  logic [7:0] ack_limit;

  logic [2:0] b_seg;
  logic [2:0] b_ph;
  logic [3:0] b_bits;
  logic [7:0] b_hold;
  logic [7:0] b_ackw;
  logic [7:0] b_shift;
  logic [6:0] b_dev;
  logic [7:0] b_reg;
  logic [7:0] b_data;
  logic       b_rd;
  logic       b_scl;
  logic       b_sda;
  logic       b_ackf;
  logic [7:0] b_rx;
  logic       b_done;

  function automatic logic [2:0] seg_kind(input logic [2:0] seg);
    return b_rd ? READ_PLAN[seg*3 +: 3] : WRITE_PLAN[seg*3 +: 3];
  endfunction

  function automatic logic [7:0] seg_byte(input logic [2:0] seg);
    logic [7:0] addr_byte;
    addr_byte = {b_dev, 1'b0};
    if (seg == 3'd2) return addr_byte;
    if (seg == 3'd3) return b_reg;
    if (!b_rd && seg == 3'd4) return b_data;
    if (b_rd && seg == 3'd5) return addr_byte | 8'd1;
    return 8'd0;
  endfunction

  function automatic void clear_sequencer();
    hold_ticks = PHASE_TICKS_RST;
    ack_limit  = ACK_TIMEOUT_RST;
    b_seg = 3'd0;  b_ph = 3'd0;  b_bits = 4'd0;  b_hold = 8'd0;
    b_ackw = 8'd0; b_shift = 8'd0; b_dev = 7'd0; b_reg = 8'd0;
    b_data = 8'd0; b_rd = 1'b0;  b_scl = 1'b1;  b_sda = 1'b1;
    b_ackf = 1'b0; b_rx = 8'd0;  b_done = 1'b0;
  endfunction

  function automatic void enter_phase(input logic [2:0] seg, input logic [2:0] ph);
    b_seg  = seg;
    b_ph   = ph;
    b_hold = 8'd0;
    case (seg_kind(seg))
      K_START: begin
        if (ph == 3'd0) b_sda = 1'b1;
        else if (ph == 3'd1) b_scl = 1'b1;
        else b_sda = 1'b0;
      end
      K_WBYTE: begin
        case (ph)
          3'd0: b_scl = 1'b0;
          3'd1: b_sda = b_shift[7];
          3'd2: b_scl = 1'b1;
          3'd3: b_scl = 1'b0;
          3'd4: b_sda = 1'b1;
          PH_ACK_WAIT: begin
            b_scl  = 1'b1;
            b_ackw = 8'd0;
          end
          default: b_scl = 1'b0;
        endcase
      end
      K_RBYTE: begin
        if (ph == 3'd0) begin
          b_scl = 1'b0;
          b_sda = 1'b1;
        end else begin
          b_scl = (ph == 3'd1) || (ph == 3'd3);
        end
      end
      K_STOP: begin
        if (ph == 3'd0) b_sda = 1'b0;
        else if (ph == 3'd1) b_scl = 1'b1;
        else b_sda = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void begin_segment(input logic [3:0] seg);
    if (seg > 4'd7 || seg_kind(seg[2:0]) == K_NONE) begin
      b_seg = 3'd0;
      b_ph  = 3'd0;
    end else begin
      b_bits  = 4'd0;
      b_shift = seg_byte(seg[2:0]);
      enter_phase(seg[2:0], 3'd0);
    end
  endfunction

  function automatic void advance();
    logic [3:0] next_seg;
    next_seg = {1'b0, b_seg} + 4'd1;
    case (seg_kind(b_seg))
      K_START: begin
        if (b_ph < 3'd2) enter_phase(b_seg, b_ph + 3'd1);
        else begin_segment(next_seg);
      end
      K_WBYTE: begin
        if (b_ph == 3'd2) begin
          b_shift = {b_shift[6:0], 1'b0};
          b_bits  = b_bits + 4'd1;
          enter_phase(b_seg, (b_bits < 4'd8) ? 3'd0 : 3'd3);
        end else if (b_ph < PH_LAST) begin
          enter_phase(b_seg, b_ph + 3'd1);
        end else begin
          begin_segment(next_seg);
        end
      end
      K_RBYTE: begin
        if (b_ph == 3'd2) begin
          b_bits = b_bits + 4'd1;
          enter_phase(b_seg, (b_bits < 4'd8) ? 3'd1 : 3'd3);
        end else if (b_ph < 3'd4) begin
          enter_phase(b_seg, b_ph + 3'd1);
        end else begin
          b_rx = b_shift;
          begin_segment(next_seg);
        end
      end
      K_STOP: begin
        if (b_ph < 3'd2) begin
          enter_phase(b_seg, b_ph + 3'd1);
        end else begin
          b_seg  = 3'd0;
          b_ph   = 3'd0;
          b_hold = 8'd0;
          b_done = 1'b1;
        end
      end
      default: begin
        b_seg = 3'd0;
        b_ph  = 3'd0;
      end
    endcase
  endfunction

  function automatic void bus_step(input logic sda);
    // While waiting for an ACK, the hold counter is not used; the wait counter is.
    if (seg_kind(b_seg) == K_WBYTE && b_ph == PH_ACK_WAIT) begin
      if (!sda) begin
        advance();
      end else begin
        if (b_ackw < 8'd255) b_ackw = b_ackw + 8'd1;
        if (b_ackw >= ack_limit) begin
          b_ackf = 1'b1;
          advance();
        end
      end
    end else begin
      if (b_hold < 8'd255) b_hold = b_hold + 8'd1;
      if (b_hold >= hold_ticks) begin
        if (seg_kind(b_seg) == K_RBYTE && b_ph == 3'd1) b_shift = {b_shift[6:0], sda};
        advance();
      end
    end
  endfunction

  function automatic bus_result_t sequence_tick(input logic [1:0] cmd, input logic [6:0] dev,
                                                input logic [7:0] ra, input logic [7:0] wd,
                                                input logic sda);
    bus_result_t r;
    logic was_busy;
    logic starts;
    was_busy = (b_seg != 3'd0);
    starts   = (cmd == CMD_WRITE) || (cmd == CMD_READ);
    b_done   = 1'b0;
    r.rejected = 1'b0;
    if (starts && !was_busy) begin
      b_dev  = dev;
      b_reg  = ra;
      b_data = wd;
      b_rd   = (cmd == CMD_READ);
      b_ackf = 1'b0;
      begin_segment(4'd1);
    end else begin
      r.rejected = starts;
      if (was_busy) bus_step(sda);
    end
    r.scl         = b_scl;
    r.sda         = b_sda;
    r.busy        = (b_seg != 3'd0);
    r.done        = b_done;
    r.rdata       = b_rx;
    r.ack_missing = b_ackf;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    bus_result_t want;
    if (!rst_n) begin
      clear_sequencer();
      due_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PHASE_TICKS) hold_ticks = cfg_wdata;
        else if (cfg_index == CFG_ACK_TIMEOUT) ack_limit = cfg_wdata;
      end
      if (in_valid && in_ready)
        due_results.push_back(sequence_tick(in_cmd, in_dev_addr, in_reg_addr,
                                            in_wr_byte, in_sda_in));
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("scl_out", 32'(want.scl), 32'(out_scl_out));
          check_field("sda_out", 32'(want.sda), 32'(out_sda_out));
          check_field("busy_res", 32'(want.busy), 32'(out_busy_res));
          check_field("done_res", 32'(want.done), 32'(out_done_res));
          check_field("read_data", 32'(want.rdata), 32'(out_read_data));
          check_field("ack_missing", 32'(want.ack_missing), 32'(out_ack_missing));
          check_field("cmd_rejected", 32'(want.rejected), 32'(out_cmd_rejected));
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// ----- sim/i2c_register_access_master_tb.sv -----
`timescale 1ns / 1ps
// Top of the I2C register access master testbench: clock, reset, stimulus and verdict.
module i2c_register_access_master_tb;
  import i2cm_pkg::*;

  // Command code three has no meaning and must act as a plain tick.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = CMD_TICK;
  logic [6:0] in_dev_addr = 7'd0;
  logic [7:0] in_reg_addr = 8'd0;
  logic [7:0] in_wr_byte = 8'd0;
  logic       in_sda_in = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_out;
  logic       out_sda_out;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_read_data;
  logic       out_ack_missing;
  logic       out_cmd_rejected;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_PHASE_TICKS;
  logic [7:0] cfg_wdata = 8'd0;

  int fail_count;
  int pending;
  int items_sent = 0;
  int pull_low_pct = 50;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  logic [7:0] hold_now = PHASE_TICKS_RST;
  logic [7:0] wait_now = ACK_TIMEOUT_RST;

  i2c_register_access_master u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_dev_addr      (in_dev_addr),
    .in_reg_addr      (in_reg_addr),
    .in_wr_byte       (in_wr_byte),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_ack_missing  (out_ack_missing),
    .out_cmd_rejected (out_cmd_rejected),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  i2c_register_access_master_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_dev_addr      (in_dev_addr),
    .in_reg_addr      (in_reg_addr),
    .in_wr_byte       (in_wr_byte),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_ack_missing  (out_ack_missing),
    .out_cmd_rejected (out_cmd_rejected),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always #5 clk = ~clk;

  // The slave side: SDA is low with the chance chosen for the current transaction.
  function automatic logic slave_sda();
    return ($urandom_range(0, 99) < pull_low_pct) ? 1'b0 : 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] cmd, input logic [6:0] dev, input logic [7:0] ra,
                           input logic [7:0] wd, input logic sda);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_dev_addr <= dev;
    in_reg_addr <= ra;
    in_wr_byte  <= wd;
    in_sda_in   <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if ($urandom_range(0, 29) == 0) src_steady = !src_steady;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_settings(input logic [7:0] hold, input logic [7:0] ack_wait);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PHASE_TICKS;
    cfg_wdata <= hold;
    @(negedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= ack_wait;
    @(negedge clk);
    cfg_we   <= 1'b0;
    hold_now = hold;
    wait_now = ack_wait;
  endtask

  // A command followed by roughly enough ticks to finish it, with a stray command now and then.
  task automatic run_transaction(input int budget);
    logic [1:0] op;
    int pick;
    int span;
    int hold_eff;
    int n;
    op = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
    pull_low_pct = $urandom_range(30, 95);
    send_item(op, 7'($urandom), 8'($urandom), 8'($urandom), slave_sda());
    hold_eff = (hold_now == 8'd0) ? 1 : hold_now;
    span = hold_eff * ((op == CMD_READ) ? 110 : 88)
           + 3 * ((wait_now < 8'd4) ? int'(wait_now) : 4) + $urandom_range(0, 12);
    n = 0;
    while (n < span && items_sent < budget) begin
      pick = $urandom_range(0, 49);
      if (pick == 0)
        send_item($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 7'($urandom), 8'($urandom),
                  8'($urandom), slave_sda());
      else if (pick == 1)
        send_item(CMD_SPARE, 7'($urandom), 8'($urandom), 8'($urandom), slave_sda());
      else
        send_item(CMD_TICK, 7'($urandom), 8'($urandom), 8'($urandom), slave_sda());
      n++;
    end
  endtask

  task automatic run_random(input int count);
    int budget;
    logic [1:0] c;
    budget = items_sent + count;
    while (items_sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        run_transaction(budget);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          c = 2'($urandom_range(0, 3));
          send_item(c, 7'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    @(negedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 19) == 0) sink_steady = !sink_steady;
    end
  end

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short directed part at the reset settings.
    send_item(CMD_TICK, 7'h7f, 8'hff, 8'hff, 1'b1);
    send_item(CMD_SPARE, 7'h7f, 8'hff, 8'hff, 1'b0);
    send_item(CMD_WRITE, 7'h7f, 8'hff, 8'hff, 1'b1);
    // Commands while a transfer sequence runs are refused.
    send_item(CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0);
    send_item(CMD_WRITE, 7'h00, 8'h00, 8'h00, 1'b1);
    send_item(CMD_SPARE, 7'h00, 8'h00, 8'h00, 1'b0);
    repeat (16) send_item(CMD_TICK, 7'h00, 8'h00, 8'h00, 1'($urandom_range(0, 1)));

    drain();
    write_settings(8'd0, 8'd0);
    run_random(250);
    drain();
    write_settings(8'd1, 8'd1);
    run_random(250);
    drain();
    write_settings(8'd255, 8'd255);
    run_random(300);
    drain();
    write_settings(8'd2, 8'd4);
    run_random(200);
    drain();
    write_settings(8'd1, 8'd200);
    run_random(150);
    drain();

    if (fail_count == 0) begin
      $display("i2c_register_access_master_tb: clean");
    end else begin
      $display("i2c_register_access_master_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("i2c_register_access_master_tb: errors");
    $finish;
  end

endmodule
